@@ src/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants and helpers for the range-max segment tree.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int DATA_W = 64;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  function automatic logic [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                             input logic signed [DATA_W-1:0] b);
    return (a >= b) ? a : b;
  endfunction

endpackage

@@ src/mst_mem.sv @@
// ----------------------------------------------------------------------------
// mst_mem
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mst_mem
  import mst_pkg::*;
#(
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] nodes [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      nodes[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= nodes[raddr];
    end
  end

endmodule

@@ src/mst_ctrl.sv @@
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer: clearing pass, leaf-to-root update walk, bottom-up range query,
// and the result output register.
// ----------------------------------------------------------------------------
module mst_ctrl
  import mst_pkg::*;
#(
  parameter int LEAVES = 1024,
  localparam int IDX_W = $clog2(LEAVES),
  localparam int AW    = IDX_W + 1,
  localparam int RW    = IDX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic [IDX_W-1:0]         leaf_index,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic [RW-1:0]            range_low,
  input  logic [RW-1:0]            range_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] range_max,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [DATA_W-1:0]        mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [DATA_W-1:0]        mem_rdata
);

  localparam int QW = IDX_W + 2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_UPD   = 5'b00100,
    S_QRY   = 5'b01000,
    S_QEND  = 5'b10000
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     cur_node;
  logic [DATA_W-1:0] cur_val;
  logic              upd_first;
  logic [QW-1:0]     ql;
  logic [QW-1:0]     qr;
  logic              qphase;
  logic              pend;
  logic [DATA_W-1:0] acc;

  logic [AW-1:0]     upd_node;
  logic [DATA_W-1:0] upd_val;
  logic [QW-1:0]     qr_m1;
  logic              q_open;
  logic [RW-1:0]     lo_sat;
  logic [RW-1:0]     hi_sat;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign qr_m1    = qr - QW'(1);
  assign q_open   = (ql < qr);
  assign lo_sat   = (range_low  > RW'(LEAVES)) ? RW'(LEAVES) : range_low;
  assign hi_sat   = (range_high > RW'(LEAVES)) ? RW'(LEAVES) : range_high;
  assign upd_node = upd_first ? cur_node : (cur_node >> 1);
  assign upd_val  = upd_first ? cur_val : smax(cur_val, mem_rdata);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = MOST_NEG;
    mem_re    = 1'b0;
    mem_raddr = ql[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = upd_node;
        mem_wdata = upd_val;
        mem_re    = (upd_node != AW'(1));
        mem_raddr = upd_node ^ AW'(1);
      end
      S_QRY: begin
        if (!qphase) begin
          mem_re    = q_open && ql[0];
          mem_raddr = ql[AW-1:0];
        end else begin
          mem_re    = qr[0];
          mem_raddr = qr_m1[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      upd_first <= 1'b0;
      qphase    <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OP_UPDATE) begin
              cur_node  <= {1'b1, leaf_index};
              cur_val   <= new_value;
              upd_first <= 1'b1;
              state     <= S_UPD;
            end else begin
              ql     <= QW'(lo_sat) + QW'(LEAVES);
              qr     <= QW'(hi_sat) + QW'(LEAVES);
              acc    <= MOST_NEG;
              qphase <= 1'b0;
              pend   <= 1'b0;
              state  <= S_QRY;
            end
          end
        end
        S_UPD: begin
          upd_first <= 1'b0;
          cur_node  <= upd_node;
          cur_val   <= upd_val;
          if (upd_node == AW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_QRY: begin
          pend <= mem_re;
          if (pend) begin
            acc <= smax(acc, mem_rdata);
          end
          if (!qphase) begin
            if (q_open) begin
              if (ql[0]) begin
                ql <= ql + QW'(1);
              end
              qphase <= 1'b1;
            end else begin
              state <= S_QEND;
            end
          end else begin
            ql     <= ql >> 1;
            qr     <= (qr[0] ? qr_m1 : qr) >> 1;
            qphase <= 1'b0;
          end
        end
        S_QEND: begin
          if (out_free) begin
            range_max <= acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_UPD))
    else $error("node write outside clear or update");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same node");

  a_rd_node: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (mem_raddr != '0))
    else $error("read of unused node zero");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_QEND))
    else $error("result raised outside query end");

  a_upd_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && upd_node == AW'(1)) |=> (state == S_IDLE))
    else $error("update walk did not stop at root");
`endif

endmodule

@@ src/max_segment_tree.sv @@
// ----------------------------------------------------------------------------
// max_segment_tree
// Range-maximum segment tree with point update, signed 64-bit values,
// node store in one synchronous memory.
//
//   channel  valid      stall       payload
//   in       in_valid   in_stall    opcode, leaf_index, new_value,
//                                   range_low, range_high
//   out      out_valid  out_stall   range_max
//
// Update: one node write per level and one sibling read per level below the
//   root, on the memory's single read port.
// Query: a walk with two read slots per tree level, then the result is loaded
//   into the output register.
// Reset: a clearing pass fills every node with the most negative value;
//   in_stall stays high through it.
// One transaction at a time; the output register lets the next transaction
//   in while a result waits on out_stall.
// ----------------------------------------------------------------------------
module max_segment_tree
  import mst_pkg::*;
#(
  parameter int LEAVES = 1024,
  localparam int IDX_W = $clog2(LEAVES),
  localparam int AW    = IDX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic [IDX_W-1:0]         leaf_index,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic [IDX_W:0]           range_low,
  input  logic [IDX_W:0]           range_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] range_max
);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  mst_ctrl #(
    .LEAVES(LEAVES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .leaf_index(leaf_index),
    .new_value (new_value),
    .range_low (range_low),
    .range_high(range_high),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .range_max (range_max),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mst_mem #(
    .AW(AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
